// File: rtl/core/mvm_pkg.sv
// Package for the matrix-vector multiply engine: constants, payload structs and helpers.
`default_nettype none

package mvm_pkg;

    // Largest supported matrix width and the address width of the vector store.
    localparam int MAX_DIM = 1024;
    localparam int ADDR_W  = $clog2(MAX_DIM);
    localparam int WIDTH_W = 11;

    // Configuration register indexes.
    localparam logic [1:0] CFG_COLUMNS   = 2'd0;
    localparam logic [1:0] CFG_FIRST_ROW = 2'd1;
    localparam logic [1:0] CFG_ROW_END   = 2'd2;

    // Item kinds.
    localparam logic KIND_VECTOR = 1'b0;
    localparam logic KIND_MATRIX = 1'b1;

    // Last row index; the row counter stops here.
    localparam logic [15:0] ROW_MAX = 16'hFFFF;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] element_value;
    } t_in_item;

    typedef struct packed {
        logic        [15:0] row_index;
        logic signed [63:0] dot_product;
        logic               saturated;
    } t_out_item;

    // Control that travels down the pipeline with each item.
    typedef struct packed {
        logic        kind;
        logic        last;
        logic        emit;
        logic [15:0] row;
    } t_token;

    // Effective matrix width: zero counts as one, values above the store depth clip.
    function automatic logic [WIDTH_W-1:0] width_now(input logic [WIDTH_W-1:0] columns);
        logic [WIDTH_W-1:0] w;
        w = columns;
        if (w == '0) w = WIDTH_W'(1);
        if (w > WIDTH_W'(MAX_DIM)) w = WIDTH_W'(MAX_DIM);
        return w;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/matrix_vector_multiply.sv
// Top level of the dense matrix-vector multiply engine.
//
// Vector beats (kind 0) fill the on-chip vector store in column order and restart the row
// counter at first_row; matrix beats (kind 1) stream row-major and each is multiplied by the
// stored element of its column and added to a saturating Q32.32 accumulator. The block takes
// one beat per cycle unless stalled: a three-stage pipeline of vector-store read, 32x32
// multiply and 64-bit saturating accumulate. A row's last beat passes stage one and stage
// two into the output register. One finished row can wait in the output register while
// beats keep flowing; the input is stalled only when a second result reaches the accumulate
// stage before the first has been taken. The vector store needs no clearing after reset.
`default_nettype none

module matrix_vector_multiply
    import mvm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write port
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    // Input channel
    input  wire logic        i_in_valid,
    output      logic        o_in_stall,
    input  wire t_in_item    i_in_item,
    // Output channel
    output      logic        o_out_valid,
    input  wire logic        i_out_stall,
    output      t_out_item   o_out_item
);

    // Configuration registers
    logic [WIDTH_W-1:0] r_columns;
    logic [15:0]        r_first_row;
    logic [15:0]        r_row_end;

    // Position counters
    logic [ADDR_W-1:0]  r_load_pos, n_load_pos;
    logic [ADDR_W-1:0]  r_col_pos,  n_col_pos;
    logic [15:0]        r_row_pos,  n_row_pos;

    // Pipeline stage one: memory read data and token
    logic               r_s1_valid;
    t_token             r_s1_tok;
    logic signed [31:0] r_s1_x;
    logic signed [31:0] r_s1_data;

    // Pipeline stage two: product and token
    logic               r_s2_valid;
    t_token             r_s2_tok;
    logic signed [63:0] r_s2_prod;

    // Accumulator and output register
    logic signed [63:0] r_acc;
    logic               r_clip;
    logic               r_out_valid;
    t_out_item          r_out_item;

    // Vector store
    logic [31:0]        r_store [MAX_DIM];

    logic               hold;
    logic               adv;
    logic               accept;
    logic               is_vec;
    logic [WIDTH_W-1:0] width;
    logic [WIDTH_W-1:0] col_next;
    logic [WIDTH_W-1:0] load_next;
    logic               row_last;
    t_token             in_tok;
    logic signed [63:0] sum;
    logic               ovf;
    logic signed [63:0] acc_sat;
    logic               clip_sum;
    logic               out_load;

    // Flow control: the pipe stops only when a result would overwrite a waiting one.
    assign hold   = r_s2_valid && (r_s2_tok.kind == KIND_MATRIX) && r_s2_tok.last &&
                    r_s2_tok.emit && r_out_valid && i_out_stall;
    assign adv    = !hold;
    assign accept = i_in_valid && adv;
    assign is_vec = (i_in_item.kind == KIND_VECTOR);

    assign o_in_stall  = hold;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns   <= WIDTH_W'(MAX_DIM);
            r_first_row <= 16'd0;
            r_row_end   <= ROW_MAX;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_COLUMNS:   r_columns   <= i_cfg_data[WIDTH_W-1:0];
                CFG_FIRST_ROW: r_first_row <= i_cfg_data;
                CFG_ROW_END:   r_row_end   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Position bookkeeping for the accepted beat.
    always_comb begin
        width     = width_now(r_columns);
        col_next  = WIDTH_W'(r_col_pos) + WIDTH_W'(1);
        load_next = WIDTH_W'(r_load_pos) + WIDTH_W'(1);
        row_last  = (col_next >= width);

        in_tok.kind = i_in_item.kind;
        in_tok.last = row_last;
        in_tok.emit = (r_row_pos < r_row_end);
        in_tok.row  = r_row_pos;

        n_load_pos = r_load_pos;
        n_col_pos  = r_col_pos;
        n_row_pos  = r_row_pos;
        if (is_vec) begin
            n_load_pos = (load_next >= width) ? '0 : load_next[ADDR_W-1:0];
            n_col_pos  = '0;
            n_row_pos  = r_first_row;
        end else if (row_last) begin
            n_col_pos = '0;
            if (r_row_pos != ROW_MAX) n_row_pos = r_row_pos + 16'd1;
        end else begin
            n_col_pos = col_next[ADDR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_pos <= '0;
            r_col_pos  <= '0;
            r_row_pos  <= 16'd0;
        end else if (accept) begin
            r_load_pos <= n_load_pos;
            r_col_pos  <= n_col_pos;
            r_row_pos  <= n_row_pos;
        end
    end

    // Vector store: vector beats write, matrix beats read their column.
    always_ff @(posedge i_clk) begin
        if (accept && is_vec) begin
            r_store[r_load_pos] <= i_in_item.element_value;
        end
        if (adv) begin
            r_s1_data <= $signed(r_store[r_col_pos]);
            r_s1_x    <= i_in_item.element_value;
            r_s1_tok  <= in_tok;
        end
    end

    // Stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= accept;
            r_s2_valid <= r_s1_valid;
        end
    end

    // Multiply stage
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2_prod <= r_s1_x * r_s1_data;
            r_s2_tok  <= r_s1_tok;
        end
    end

    // Saturating add of the product into the accumulator.
    always_comb begin
        sum      = r_acc + r_s2_prod;
        ovf      = (r_acc[63] == r_s2_prod[63]) && (sum[63] != r_acc[63]);
        acc_sat  = ovf ? (r_acc[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}) : sum;
        clip_sum = r_clip | ovf;
        out_load = adv && r_s2_valid && (r_s2_tok.kind == KIND_MATRIX) &&
                   r_s2_tok.last && r_s2_tok.emit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_clip <= 1'b0;
        end else if (adv && r_s2_valid) begin
            if (r_s2_tok.kind == KIND_VECTOR || r_s2_tok.last) begin
                r_acc  <= '0;
                r_clip <= 1'b0;
            end else begin
                r_acc  <= acc_sat;
                r_clip <= clip_sum;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_item.row_index   <= r_s2_tok.row;
            r_out_item.dot_product <= acc_sat;
            r_out_item.saturated   <= clip_sum;
        end
    end

    // A waiting result is never overwritten.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(out_load && r_out_valid && i_out_stall))
        else $error("result loaded over a stalled result");

    // A vector beat enters stage one as a vector token.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && is_vec) |=> (r_s1_valid && r_s1_tok.kind == KIND_VECTOR))
        else $error("vector beat lost in stage one");

    // A vector beat restarts the column count.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && is_vec) |=> (r_col_pos == '0))
        else $error("column position not cleared by vector beat");

endmodule

`default_nettype wire
